// ----- sv/cvw_pkg.sv -----
// cvw_pkg: shared constants, register codes and beat types for the 3x3 valid-window correlator
// used by every module of conv2d_valid_window_top; no dependencies
package cvw_pkg;

  localparam int unsigned MaxWidth = 1024;
  localparam int unsigned ColW     = $clog2(MaxWidth);
  localparam int unsigned WidthW   = ColW + 1;
  localparam int unsigned MinWidth = 3;
  localparam int unsigned DefWidth = 640;
  localparam int unsigned RowW     = 10;
  localparam int unsigned RowSat   = (1 << RowW) - 1;
  localparam int unsigned KSize    = 3;
  localparam int unsigned PixW     = 8;
  localparam int unsigned LineW    = 2 * PixW;
  localparam int unsigned CoefW    = 16;
  localparam int unsigned CfgW     = KSize * CoefW;
  localparam int unsigned ProdW    = 24;
  localparam int unsigned RowSumW  = 26;
  localparam int unsigned SumW     = 28;
  localparam int unsigned CfgAddrW = 2;

  typedef enum logic [CfgAddrW-1:0] {
    REG_WIDTH    = 2'd0,
    REG_COEF_TOP = 2'd1,
    REG_COEF_MID = 2'd2,
    REG_COEF_BOT = 2'd3
  } cfg_reg_e;

  // coef[k][l]: kernel row k, column l
  typedef struct packed {
    logic [WidthW-1:0]                  width;
    logic [KSize-1:0][KSize-1:0][CoefW-1:0] coef;
  } cfg_t;

  // pixel beat after the column/row counters
  typedef struct packed {
    logic            valid;
    logic [PixW-1:0] pix;
    logic [ColW-1:0] col;
    logic [RowW-1:0] row;
  } beat_t;

endpackage

// ----- sv/cvw_cfg_regs.sv -----
// cvw_cfg_regs: image width and kernel coefficient registers with width clamping
// depends on cvw_pkg
module cvw_cfg_regs (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [cvw_pkg::CfgAddrW-1:0]  cfg_addr_i,
  input  logic [cvw_pkg::CfgW-1:0]      cfg_wdata_i,
  output cvw_pkg::cfg_t                 cfg_o
);

  logic [cvw_pkg::WidthW-1:0]                 width_q;
  logic [cvw_pkg::KSize-1:0][cvw_pkg::CfgW-1:0] coef_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q <= cvw_pkg::WidthW'(cvw_pkg::DefWidth);
      coef_q  <= '0;
    end else if (cfg_we_i) begin
      unique case (cvw_pkg::cfg_reg_e'(cfg_addr_i))
        cvw_pkg::REG_WIDTH:    width_q   <= cfg_wdata_i[cvw_pkg::WidthW-1:0];
        cvw_pkg::REG_COEF_TOP: coef_q[0] <= cfg_wdata_i;
        cvw_pkg::REG_COEF_MID: coef_q[1] <= cfg_wdata_i;
        cvw_pkg::REG_COEF_BOT: coef_q[2] <= cfg_wdata_i;
      endcase
    end
  end

  always_comb begin
    priority if (width_q < cvw_pkg::WidthW'(cvw_pkg::MinWidth)) begin
      cfg_o.width = cvw_pkg::WidthW'(cvw_pkg::MinWidth);
    end else if (width_q > cvw_pkg::WidthW'(cvw_pkg::MaxWidth)) begin
      cfg_o.width = cvw_pkg::WidthW'(cvw_pkg::MaxWidth);
    end else begin
      cfg_o.width = width_q;
    end
    for (int k = 0; k < cvw_pkg::KSize; k++) begin
      cfg_o.coef[k] = coef_q[k];
    end
  end

endmodule

// ----- sv/cvw_line_buf.sv -----
// cvw_line_buf: two packed line stores, one word per column, registered read with write bypass
// depends on cvw_pkg
module cvw_line_buf (
  input  logic                       clk_i,
  input  logic                       rd_en_i,
  input  logic [cvw_pkg::ColW-1:0]   rd_addr_i,
  input  logic                       wr_en_i,
  input  logic [cvw_pkg::ColW-1:0]   wr_addr_i,
  input  logic [cvw_pkg::LineW-1:0]  wr_data_i,
  output logic [cvw_pkg::LineW-1:0]  rd_data_o
);

  // low byte: older line, high byte: newer line
  logic [cvw_pkg::LineW-1:0] mem_q [cvw_pkg::MaxWidth];
  logic [cvw_pkg::LineW-1:0] rd_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      if (wr_en_i && (wr_addr_i == rd_addr_i)) begin
        rd_q <= wr_data_i;
      end else begin
        rd_q <= mem_q[rd_addr_i];
      end
    end
  end

  assign rd_data_o = rd_q;

endmodule

// ----- sv/cvw_mac.sv -----
// cvw_mac: 3x3 window shift, nine parallel products, two-level registered adder tree
// depends on cvw_pkg
module cvw_mac (
  input  logic                                              clk_i,
  input  logic                                              rst_ni,
  input  logic                                              adv_i,
  input  cvw_pkg::beat_t                                    s1_i,
  input  logic [cvw_pkg::LineW-1:0]                         line_i,
  input  logic [cvw_pkg::KSize-1:0][cvw_pkg::KSize-1:0][cvw_pkg::CoefW-1:0] coef_i,
  output logic                                              out_valid_o,
  output logic signed [cvw_pkg::SumW-1:0]                   conv_sum_o,
  output logic [cvw_pkg::RowW-1:0]                          out_row_o,
  output logic [cvw_pkg::ColW-1:0]                          out_column_o
);

  localparam int unsigned KS = cvw_pkg::KSize;

  logic [cvw_pkg::PixW-1:0]          win_q [KS][KS];
  logic [cvw_pkg::PixW-1:0]          win_d [KS][KS];
  logic signed [cvw_pkg::ProdW:0]    prod_full [KS][KS];
  logic                              hit;

  logic                              p_valid_q;
  logic signed [cvw_pkg::ProdW-1:0]  prod_q [KS][KS];
  logic [cvw_pkg::RowW-1:0]          p_row_q;
  logic [cvw_pkg::ColW-1:0]          p_col_q;

  logic                              r_valid_q;
  logic signed [cvw_pkg::RowSumW-1:0] rsum_q [KS];
  logic [cvw_pkg::RowW-1:0]          r_row_q;
  logic [cvw_pkg::ColW-1:0]          r_col_q;

  logic                              o_valid_q;
  logic signed [cvw_pkg::SumW-1:0]   sum_q;
  logic [cvw_pkg::RowW-1:0]          o_row_q;
  logic [cvw_pkg::ColW-1:0]          o_col_q;

  always_comb begin
    for (int r = 0; r < KS; r++) begin
      for (int c = 0; c < KS - 1; c++) begin
        win_d[r][c] = win_q[r][c+1];
      end
    end
    win_d[0][KS-1] = line_i[cvw_pkg::PixW-1:0];
    win_d[1][KS-1] = line_i[cvw_pkg::LineW-1:cvw_pkg::PixW];
    win_d[2][KS-1] = s1_i.pix;
    for (int k = 0; k < KS; k++) begin
      for (int l = 0; l < KS; l++) begin
        prod_full[k][l] = $signed({1'b0, win_d[k][l]}) * $signed(coef_i[k][l]);
      end
    end
  end

  assign hit = s1_i.valid && (s1_i.row >= cvw_pkg::RowW'(KS - 1))
                          && (s1_i.col >= cvw_pkg::ColW'(KS - 1));

  always_ff @(posedge clk_i) begin
    if (adv_i && s1_i.valid) begin
      win_q <= win_d;
    end
  end

  // valid pipeline
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p_valid_q <= 1'b0;
      r_valid_q <= 1'b0;
      o_valid_q <= 1'b0;
    end else if (adv_i) begin
      p_valid_q <= hit;
      r_valid_q <= p_valid_q;
      o_valid_q <= r_valid_q;
    end
  end

  // payload pipeline
  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      if (hit) begin
        for (int k = 0; k < KS; k++) begin
          for (int l = 0; l < KS; l++) begin
            prod_q[k][l] <= prod_full[k][l][cvw_pkg::ProdW-1:0];
          end
        end
        p_row_q <= s1_i.row - cvw_pkg::RowW'(KS - 1);
        p_col_q <= s1_i.col - cvw_pkg::ColW'(KS - 1);
      end
      if (p_valid_q) begin
        for (int k = 0; k < KS; k++) begin
          rsum_q[k] <= {{2{prod_q[k][0][cvw_pkg::ProdW-1]}}, prod_q[k][0]}
                     + {{2{prod_q[k][1][cvw_pkg::ProdW-1]}}, prod_q[k][1]}
                     + {{2{prod_q[k][2][cvw_pkg::ProdW-1]}}, prod_q[k][2]};
        end
        r_row_q <= p_row_q;
        r_col_q <= p_col_q;
      end
      if (r_valid_q) begin
        sum_q   <= {{2{rsum_q[0][cvw_pkg::RowSumW-1]}}, rsum_q[0]}
                 + {{2{rsum_q[1][cvw_pkg::RowSumW-1]}}, rsum_q[1]}
                 + {{2{rsum_q[2][cvw_pkg::RowSumW-1]}}, rsum_q[2]};
        o_row_q <= r_row_q;
        o_col_q <= r_col_q;
      end
    end
  end

  assign out_valid_o  = o_valid_q;
  assign conv_sum_o   = sum_q;
  assign out_row_o    = o_row_q;
  assign out_column_o = o_col_q;

endmodule

// ----- sv/conv2d_valid_window_top.sv -----
// conv2d_valid_window_top: 3x3 valid-region correlation over a raster pixel stream
// depends on cvw_pkg, cvw_cfg_regs, cvw_line_buf, cvw_mac
//
//   channel  signals                                         direction
//   in       in_valid_i, in_stall_o, pixel_i, frame_start_i   pixel beats in
//   out      out_valid_o, out_stall_i, conv_sum_o,            result beats out
//            out_row_o, out_column_o
//   cfg      cfg_we_i, cfg_addr_i, cfg_wdata_i                register writes
//
// one pixel per cycle sustained while the output is not stalled
// pipeline: counter/line-store read stage, window and multiply stage, two adder stages
// the line store is not cleared after reset; rows 0 and 1 of a frame fill it
// in_stall_o comes from a one-beat skid register, so it is registered
// a stalled output freezes the whole pipeline, the skid absorbs one more beat
module conv2d_valid_window_top (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 cfg_we_i,
  input  logic [cvw_pkg::CfgAddrW-1:0]         cfg_addr_i,
  input  logic [cvw_pkg::CfgW-1:0]             cfg_wdata_i,
  input  logic                                 in_valid_i,
  output logic                                 in_stall_o,
  input  logic [cvw_pkg::PixW-1:0]             pixel_i,
  input  logic                                 frame_start_i,
  output logic                                 out_valid_o,
  input  logic                                 out_stall_i,
  output logic signed [cvw_pkg::SumW-1:0]      conv_sum_o,
  output logic [cvw_pkg::RowW-1:0]             out_row_o,
  output logic [cvw_pkg::ColW-1:0]             out_column_o
);

  cvw_pkg::cfg_t                cfg;
  logic                         adv;
  logic                         accept;

  logic                         skid_valid_q;
  logic [cvw_pkg::PixW-1:0]     skid_pix_q;
  logic                         skid_fs_q;

  logic                         ent_valid;
  logic [cvw_pkg::PixW-1:0]     ent_pix;
  logic                         ent_fs;

  logic [cvw_pkg::ColW-1:0]     col_q;
  logic [cvw_pkg::RowW-1:0]     row_q;
  logic [cvw_pkg::ColW-1:0]     cur_col;
  logic [cvw_pkg::RowW-1:0]     cur_row;
  logic                         row_end;

  cvw_pkg::beat_t               s1_q;
  logic [cvw_pkg::LineW-1:0]    line_rd;
  logic                         wr_en;
  logic [cvw_pkg::LineW-1:0]    wr_data;

  cvw_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_addr_i  (cfg_addr_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  assign adv        = !out_valid_o || !out_stall_i;
  assign in_stall_o = skid_valid_q;
  assign accept     = in_valid_i && !skid_valid_q;

  assign ent_valid = skid_valid_q || in_valid_i;
  assign ent_pix   = skid_valid_q ? skid_pix_q : pixel_i;
  assign ent_fs    = skid_valid_q ? skid_fs_q  : frame_start_i;

  // skid beat
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      skid_valid_q <= 1'b0;
    end else if (adv) begin
      skid_valid_q <= 1'b0;
    end else if (accept) begin
      skid_valid_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!adv && accept) begin
      skid_pix_q <= pixel_i;
      skid_fs_q  <= frame_start_i;
    end
  end

  // raster position
  always_comb begin
    cur_col = ent_fs ? '0 : col_q;
    cur_row = ent_fs ? '0 : row_q;
    row_end = ({1'b0, cur_col} + cvw_pkg::WidthW'(1)) >= cfg.width;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
    end else if (adv && ent_valid) begin
      if (row_end) begin
        col_q <= '0;
        if (cur_row < cvw_pkg::RowW'(cvw_pkg::RowSat)) begin
          row_q <= cur_row + cvw_pkg::RowW'(1);
        end else begin
          row_q <= cur_row;
        end
      end else begin
        col_q <= cur_col + cvw_pkg::ColW'(1);
        row_q <= cur_row;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_q <= '0;
    end else if (adv) begin
      s1_q.valid <= ent_valid;
      s1_q.pix   <= ent_pix;
      s1_q.col   <= cur_col;
      s1_q.row   <= cur_row;
    end
  end

  // line rotation: older line takes the newer one, newer line takes the pixel
  assign wr_en   = adv && s1_q.valid;
  assign wr_data = {s1_q.pix, line_rd[cvw_pkg::LineW-1:cvw_pkg::PixW]};

  cvw_line_buf u_line (
    .clk_i     (clk_i),
    .rd_en_i   (adv),
    .rd_addr_i (cur_col),
    .wr_en_i   (wr_en),
    .wr_addr_i (s1_q.col),
    .wr_data_i (wr_data),
    .rd_data_o (line_rd)
  );

  cvw_mac u_mac (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .adv_i        (adv),
    .s1_i         (s1_q),
    .line_i       (line_rd),
    .coef_i       (cfg.coef),
    .out_valid_o  (out_valid_o),
    .conv_sum_o   (conv_sum_o),
    .out_row_o    (out_row_o),
    .out_column_o (out_column_o)
  );

endmodule

// ----- sv/cvw_checker.sv -----
// cvw_checker: port-level assertions for conv2d_valid_window_top, bound to the top level
// depends on cvw_pkg and conv2d_valid_window_top
module cvw_checker (
  input logic                                 clk_i,
  input logic                                 rst_ni,
  input logic                                 in_stall_o,
  input logic                                 out_valid_o,
  input logic                                 out_stall_i,
  input logic signed [cvw_pkg::SumW-1:0]      conv_sum_o,
  input logic [cvw_pkg::RowW-1:0]             out_row_o,
  input logic [cvw_pkg::ColW-1:0]             out_column_o
);

  // held result beat
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(conv_sum_o)
      && $stable(out_row_o) && $stable(out_column_o))
    else $error("result beat changed while stalled");

  // input back-pressure only follows a stalled result
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(in_stall_o) |-> $past(out_valid_o && out_stall_i))
    else $error("input stalled without output back-pressure");

  // skid drains whenever the pipeline moves
  a_skid_drain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!out_valid_o || !out_stall_i) |=> !in_stall_o)
    else $error("input still stalled after pipeline advanced");

  // valid-region column bound
  a_col_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_column_o <= cvw_pkg::ColW'(cvw_pkg::MaxWidth - cvw_pkg::KSize)))
    else $error("result column outside valid region");

endmodule

bind conv2d_valid_window_top cvw_checker u_cvw_checker (.*);
